// ===== sv/dst_type1_row_transform_macros.svh =====
// Assertion macros shared by the row transform modules.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef DST_TYPE1_ROW_TRANSFORM_MACROS_SVH
`define DST_TYPE1_ROW_TRANSFORM_MACROS_SVH

// Same-cycle implication.
`define DST1_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DST1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dst1_pkg.sv =====
// Shared types and constants for the type-I sine row transform.
// No dependencies.
package dst1_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = -24'sh800000;

  localparam longint unsigned PI_Q31 = 64'd6746518852;
  localparam int TAYLOR_TERMS = 10;
  localparam longint unsigned TAYLOR_DIV [1:TAYLOR_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  localparam logic [1:0] JOBQ_DEPTH = 2'd2;

  typedef struct packed {
    logic bank;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last_m;
    logic last_j;
  } mac_tag_t;

endpackage

// ===== sv/dst_type1_row_transform.sv =====
// Type-I discrete sine transform of one grid row, orthonormal, fixed point.
// Top level; depends on dst1_pkg, dst1_front, dst1_jobq and dst1_back.
//
// Usage:
//   Input: drive in_sample with start high; the sample is taken at a rising edge where
//   busy is low. Samples arrive in row order, ROW_POINTS (N) to a row.
//   Output: out_valid is high for one cycle per coefficient, with out_coefficient and
//   out_last (high on the final coefficient of the row). The receiver cannot stall.
//   Timing: the row memory has two banks, so the next row can be loaded while the
//   current one is transformed; busy rises only when both banks hold rows awaiting or
//   under computation. One shared 16x16 multiplier does the N*N products of a row, one
//   per cycle while the row is computed. With the engine idle, the first coefficient appears
//   once the first N products of its row have passed the multiply, accumulate, scale and
//   output registers; the rest follow in index order.
//   Reset: clears the fill counter, frees both banks, empties the job queue and the
//   pipeline. The sine table and scale factor are constants, so there is no setup pass.
module dst_type1_row_transform
  import dst1_pkg::*;
#(
  parameter int ROW_POINTS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  output logic signed [COEF_W-1:0]   out_coefficient,
  output logic                       out_last
);

  localparam int AW = $clog2(ROW_POINTS) + 1;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic signed [SAMPLE_W-1:0] wr_data;
  logic                       push;
  job_t                       push_job;
  logic                       pop;
  logic                       q_valid;
  job_t                       q_head;
  rel_t                       rel;

  dst1_front #(
    .ROW_POINTS(ROW_POINTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_sample(in_sample),
    .busy     (busy),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .push     (push),
    .push_job (push_job),
    .rel      (rel)
  );

  dst1_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  dst1_back #(
    .ROW_POINTS(ROW_POINTS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .pop            (pop),
    .rel            (rel),
    .out_coefficient(out_coefficient),
    .out_last       (out_last),
    .out_valid      (out_valid)
  );

endmodule

// ===== sv/dst1_front.sv =====
// Input side: row fill counter, bank selection and bank ownership.
// Depends on dst1_pkg and dst_type1_row_transform_macros.svh.
`include "dst_type1_row_transform_macros.svh"
module dst1_front
  import dst1_pkg::*;
#(
  parameter int ROW_POINTS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       busy,
  output logic                       wr_en,
  output logic [$clog2(ROW_POINTS):0] wr_addr,
  output logic signed [SAMPLE_W-1:0] wr_data,
  output logic                       push,
  output job_t                       push_job,
  input  rel_t                       rel
);

  localparam int PW = $clog2(ROW_POINTS);
  localparam logic [PW-1:0] LAST_IDX = PW'(ROW_POINTS - 1);

  logic [PW-1:0] fill_r;
  logic          bank_r;
  logic [1:0]    in_use_r;
  logic [1:0]    in_use_nxt;
  logic          accept;
  logic          row_end;

  assign busy     = in_use_r[bank_r];
  assign accept   = start & ~busy;
  assign row_end  = accept & (fill_r == LAST_IDX);
  assign wr_en    = accept;
  assign wr_addr  = {bank_r, fill_r};
  assign wr_data  = in_sample;
  assign push     = row_end;
  assign push_job.bank = bank_r;

  always_comb begin
    in_use_nxt = in_use_r;
    if (rel.valid) begin
      in_use_nxt[rel.bank] = 1'b0;
    end
    if (row_end) begin
      in_use_nxt[bank_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      bank_r   <= 1'b0;
      in_use_r <= '0;
    end else begin
      in_use_r <= in_use_nxt;
      if (accept) begin
        fill_r <= row_end ? '0 : fill_r + 1'b1;
        if (row_end) begin
          bank_r <= ~bank_r;
        end
      end
    end
  end

  `DST1_ASSERT_IMPL(a_rel_owned, rel.valid, in_use_r[rel.bank], "release of a free bank")

endmodule

// ===== sv/dst1_jobq.sv =====
// Two-entry queue of row jobs between the input side and the compute engine.
// Depends on dst1_pkg and dst_type1_row_transform_macros.svh.
`include "dst_type1_row_transform_macros.svh"
module dst1_jobq
  import dst1_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic q_valid,
  output job_t q_head
);

  job_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `DST1_ASSERT_IMPL(a_no_overflow, push, cnt_r != JOBQ_DEPTH, "job queue overflow")
  `DST1_ASSERT_IMPL(a_no_underflow, pop, cnt_r != 2'd0, "job queue underflow")

endmodule

// ===== sv/dst1_back.sv =====
// Compute engine: two-bank row memory, sine table, shared MAC pipeline and output stage.
// Depends on dst1_pkg and dst_type1_row_transform_macros.svh.
`include "dst_type1_row_transform_macros.svh"
module dst1_back
  import dst1_pkg::*;
#(
  parameter int ROW_POINTS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [$clog2(ROW_POINTS):0] wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic                       q_valid,
  input  job_t                       q_head,
  output logic                       pop,
  output rel_t                       rel,
  output logic signed [COEF_W-1:0]   out_coefficient,
  output logic                       out_last,
  output logic                       out_valid
);

  localparam int PW        = $clog2(ROW_POINTS);
  localparam int AW        = PW + 1;
  localparam int SPAN      = ROW_POINTS + 1;
  localparam int SPAN_HALF = SPAN / 2;
  localparam int ROM_DEPTH = 2 * SPAN;
  localparam int KW        = $clog2(ROM_DEPTH);
  localparam int ACC_W     = 32 + PW;
  localparam int SW        = ACC_W + 17;
  localparam logic [PW-1:0] LAST_IDX = PW'(ROW_POINTS - 1);
  localparam longint unsigned NORM_RADICAND = (64'd1 << 35) / SPAN;

  function automatic logic signed [15:0] sine_entry(input int k);
    logic              neg;
    longint unsigned   r;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint            q;
    neg = (k >= SPAN);
    r   = neg ? 64'(k - SPAN) : 64'(k);
    if (2 * r > SPAN) begin
      r = SPAN - r;
    end
    x    = (PI_Q31 * r + SPAN_HALF) / SPAN;
    x2   = (x * x) >> 31;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 31) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 32768) >>> 16;
    if (q > 32767) begin
      q = 32767;
    end
    return neg ? 16'(-q) : 16'(q);
  endfunction

  function automatic logic [16:0] norm_q16(input longint unsigned radicand);
    longint unsigned v;
    longint unsigned res;
    longint unsigned b;
    v   = radicand;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) begin
      b = b >> 2;
    end
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return 17'((res + 1) >> 1);
  endfunction

  localparam logic signed [16:0] NORM_S = norm_q16(NORM_RADICAND);
  localparam logic signed [SW:0] HALF_LSB = (SW + 1)'(2 ** 30);
  localparam logic signed [SW:0] CMAX = (SW + 1)'(COEF_MAX);
  localparam logic signed [SW:0] CMIN = (SW + 1)'(COEF_MIN);

  logic signed [15:0] sine_rom [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic signed [15:0] ENTRY = sine_entry(g);
    assign sine_rom[g] = ENTRY;
  end

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t state_r;

  logic signed [SAMPLE_W-1:0] row_mem [2 ** AW];

  logic          bank_r;
  logic [PW-1:0] j_r;
  logic [PW-1:0] m_r;
  logic [KW-1:0] k_r;
  logic [KW-1:0] step_r;
  logic          m_last;
  logic          j_last;
  logic [KW:0]   k_sum;
  logic [KW-1:0] k_adv;

  mac_tag_t tag1_r;
  mac_tag_t tag2_r;
  logic     sum_v_r;
  logic     sum_last_r;
  logic     v4_r;
  logic     last4_r;
  logic     out_valid_r;
  logic     out_last_r;
  logic signed [COEF_W-1:0] out_coefficient_r;

  logic signed [SAMPLE_W-1:0] x1_r;
  logic signed [15:0]         sin1_r;
  logic signed [31:0]         prod2_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [ACC_W-1:0]    sum_r;
  logic signed [SW-1:0]       scaled4_r;
  logic signed [SW:0]         rnd_w;
  logic signed [COEF_W-1:0]   sat_w;

  assign m_last = (m_r == LAST_IDX);
  assign j_last = (j_r == LAST_IDX);
  assign k_sum  = {1'b0, k_r} + {1'b0, step_r};
  assign k_adv  = (k_sum >= (KW + 1)'(ROM_DEPTH)) ? KW'(k_sum - (KW + 1)'(ROM_DEPTH))
                                                  : k_sum[KW-1:0];

  assign pop       = (state_r == ST_IDLE) & q_valid;
  assign rel.valid = (state_r == ST_RUN) & m_last & j_last;
  assign rel.bank  = bank_r;

  assign acc_nxt = tag2_r.first ? ACC_W'(prod2_r) : acc_r + ACC_W'(prod2_r);
  assign rnd_w   = ($signed({scaled4_r[SW-1], scaled4_r}) + HALF_LSB) >>> 31;
  assign sat_w   = (rnd_w > CMAX) ? COEF_MAX :
                   (rnd_w < CMIN) ? COEF_MIN : rnd_w[COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
    if (state_r == ST_RUN) begin
      x1_r <= row_mem[{bank_r, m_r}];
    end
  end

  always_ff @(posedge clk) begin
    sin1_r    <= sine_rom[k_r];
    prod2_r   <= x1_r * sin1_r;
    scaled4_r <= sum_r * NORM_S;
    if (tag2_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (tag2_r.valid & tag2_r.last_m) begin
      sum_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tag1_r      <= '0;
      tag2_r      <= '0;
      sum_v_r     <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tag2_r            <= tag1_r;
      sum_v_r           <= tag2_r.valid & tag2_r.last_m;
      sum_last_r        <= tag2_r.last_j;
      v4_r              <= sum_v_r;
      last4_r           <= sum_last_r;
      out_valid_r       <= v4_r;
      out_last_r        <= last4_r;
      out_coefficient_r <= sat_w;
      case (state_r)
        ST_IDLE: begin
          tag1_r <= '0;
          if (q_valid) begin
            state_r <= ST_RUN;
            bank_r  <= q_head.bank;
            j_r     <= '0;
            m_r     <= '0;
            k_r     <= KW'(1);
            step_r  <= KW'(1);
          end
        end
        ST_RUN: begin
          tag1_r <= {1'b1, (m_r == '0), m_last, j_last};
          if (m_last) begin
            m_r    <= '0;
            j_r    <= j_r + 1'b1;
            step_r <= step_r + 1'b1;
            k_r    <= step_r + 1'b1;
            if (j_last) begin
              state_r <= ST_IDLE;
            end
          end else begin
            m_r <= m_r + 1'b1;
            k_r <= k_adv;
          end
        end
        default: begin
          state_r <= ST_IDLE;
          tag1_r  <= '0;
        end
      endcase
    end
  end

  assign out_coefficient = out_coefficient_r;
  assign out_last        = out_last_r;
  assign out_valid       = out_valid_r;

  `DST1_ASSERT_NEXT(a_out_spaced, out_valid_r, !out_valid_r, "coefficients closer than one row step")

endmodule
